/* rtl/core/sha256h_pkg.sv */
package sha256h_pkg;

  // control from the byte sequencer to the compression unit
  typedef struct packed {
    logic start;  // load block and chaining words, begin 64 rounds
    logic init;   // reload the initial hash values
  } sha256h_ctrl_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* rtl/core/sha256h_core.sv */
module sha256h_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sha256h_pkg::sha256h_ctrl_t ctrl_i,
  input  logic [511:0]               block_i,
  output logic                       done_o,
  output logic [255:0]               hash_o
);

  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [5:0]  round_q, round_d;
  logic        run_q, run_d;
  logic        add_q, add_d;

  logic [31:0] t1, t2, w_new;

  assign t1 = v_q[7] + sha256h_pkg::big_sig1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256h_pkg::RoundK[round_q] + w_q[0];
  assign t2 = sha256h_pkg::big_sig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  // schedule window: w_q[0] is the word of the current round
  assign w_new = sha256h_pkg::small_sig1(w_q[14]) + w_q[9]
               + sha256h_pkg::small_sig0(w_q[1]) + w_q[0];

  assign done_o = add_q;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hash_o[255 - 32 * j -: 32] = h_q[j];
    end
  end

  always_comb begin
    h_d     = h_q;
    v_d     = v_q;
    w_d     = w_q;
    round_d = round_q;
    run_d   = run_q;
    add_d   = 1'b0;
    if (ctrl_i.init) begin
      h_d = sha256h_pkg::InitHash;
    end else if (ctrl_i.start) begin
      v_d     = h_q;
      round_d = '0;
      run_d   = 1'b1;
      for (int j = 0; j < 16; j++) begin
        w_d[j] = block_i[511 - 32 * j -: 32];
      end
    end else if (run_q) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      for (int j = 0; j < 15; j++) begin
        w_d[j] = w_q[j + 1];
      end
      w_d[15] = w_new;
      round_d = round_q + 6'd1;
      if (round_q == 6'd63) begin
        run_d = 1'b0;
        add_d = 1'b1;
      end
    end else if (add_q) begin
      for (int j = 0; j < 8; j++) begin
        h_d[j] = h_q[j] + v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= sha256h_pkg::InitHash;
      round_q <= '0;
      run_q   <= 1'b0;
      add_q   <= 1'b0;
    end else begin
      h_q     <= h_d;
      round_q <= round_d;
      run_q   <= run_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

endmodule

/* rtl/core/sha256_byte_stream_hasher.sv */
// a byte word is taken in S_IDLE; a byte that completes a 64-byte block holds ready
// low while the shared round unit runs 64 rounds at one per cycle
// end of message: padding bytes are shifted in one per cycle (up to 64 + 8), with one
// or two compressions; four digest words then go out one per cycle of m_tready_i
// rst_ni is asynchronous and active low: initial hash values, empty block, zero length
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] message_byte
  input  logic        s_tuser_i,   // byte_present
  input  logic        s_tlast_i,   // end_of_message
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [71:0] m_tdata_o,   // [63:0] digest_word, [65:64] word_number, zero fill
  output logic        m_tlast_o    // last_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_HASH = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  total_q, total_d;
  logic [511:0] blk_q, blk_d;
  logic         end_q, end_d;
  logic         pad80_q, pad80_d;
  logic         len_q, len_d;
  logic         start_q, start_d;
  logic [1:0]   wcnt_q, wcnt_d;

  logic         push;
  logic [7:0]   push_byte;
  logic         init;
  logic         core_done;
  logic [255:0] hash;

  sha256h_pkg::sha256h_ctrl_t ctrl;

  assign ctrl.start = start_q;
  assign ctrl.init  = init;

  sha256h_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (blk_q),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  assign m_tvalid_o = (state_q == S_OUT);
  assign m_tlast_o  = (wcnt_q == 2'd3);
  assign m_tdata_o  = {6'd0, wcnt_q, hash[{~wcnt_q, 6'd0} +: 64]};

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    total_d    = total_q;
    blk_d      = blk_q;
    end_d      = end_q;
    pad80_d    = pad80_q;
    len_d      = len_q;
    start_d    = 1'b0;
    wcnt_d     = wcnt_q;
    push       = 1'b0;
    push_byte  = s_tdata_i;
    init       = 1'b0;
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (s_tuser_i) begin
            push    = 1'b1;
            total_d = total_q + 64'd8;
          end
          if (s_tuser_i && fill_q == 6'd63) begin
            state_d = S_HASH;
            start_d = 1'b1;
            end_d   = s_tlast_i;
            pad80_d = s_tlast_i;
            len_d   = 1'b0;
          end else if (s_tlast_i) begin
            state_d = S_PAD;
            end_d   = 1'b1;
            pad80_d = 1'b1;
            len_d   = 1'b0;
          end
        end
      end
      S_PAD: begin
        push = 1'b1;
        if (pad80_q) begin
          push_byte = sha256h_pkg::PadByte;
          pad80_d   = 1'b0;
        end else if (len_q || fill_q == sha256h_pkg::LenStart) begin
          // big-endian bit count, most significant byte at offset 56
          push_byte = total_q[{~fill_q[2:0], 3'd0} +: 8];
          len_d     = 1'b1;
        end else begin
          push_byte = 8'd0;
        end
        if (fill_q == 6'd63) begin
          state_d = S_HASH;
          start_d = 1'b1;
        end
      end
      S_HASH: begin
        if (core_done) begin
          if (len_q) begin
            state_d = S_OUT;
            wcnt_d  = 2'd0;
          end else if (end_q) begin
            state_d = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (m_tready_i) begin
          wcnt_d = wcnt_q + 2'd1;
          if (wcnt_q == 2'd3) begin
            state_d = S_IDLE;
            init    = 1'b1;
            total_d = '0;
            end_d   = 1'b0;
            len_d   = 1'b0;
            pad80_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (push) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      end_q   <= 1'b0;
      pad80_q <= 1'b0;
      len_q   <= 1'b0;
      start_q <= 1'b0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      end_q   <= end_d;
      pad80_q <= pad80_d;
      len_q   <= len_d;
      start_q <= start_d;
      wcnt_q  <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule
